@@ design/vmam_pkg.sv @@
`timescale 1ns / 1ps
package vmam_pkg;

  localparam int TABLE_BYTES = 1024;
  localparam int NT_DEPTH    = 4 * TABLE_BYTES;
  localparam int NT_AW       = $clog2(NT_DEPTH);
  localparam int OFFS_W      = $clog2(TABLE_BYTES);
  localparam int PAL_DEPTH   = 32;
  localparam int PAL_AW      = $clog2(PAL_DEPTH);
  localparam int VADDR_W     = 14;
  localparam int DATA_W      = 8;
  localparam int CADDR_W     = 13;
  localparam int CFG_DW      = 32;
  localparam int PADDR_W     = 3;
  localparam int MODE_W      = 3;

  // Register index as seen on paddr[2].
  localparam logic [0:0] REG_MIRROR_MODE = 1'b0;

  // Upper six bits of a palette address.
  localparam logic [5:0] PAL_PAGE = 6'h3F;

  typedef enum logic [MODE_W-1:0] {
    MIRROR_HORIZONTAL = 3'd0,
    MIRROR_VERTICAL   = 3'd1,
    MIRROR_SINGLE0    = 3'd2,
    MIRROR_SINGLE1    = 3'd3,
    MIRROR_FOUR       = 3'd4
  } mirror_mode_t;

  typedef enum logic [0:0] {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } vmam_state_t;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Nametable fold; the 0x3000 mirror and the 0x2000 base only touch bits 12 and up.
  function automatic logic [NT_AW-1:0] nt_fold(logic [VADDR_W-1:0] a, logic [MODE_W-1:0] mode);
    logic [1:0] tbl;
    tbl = a[OFFS_W+1:OFFS_W];
    unique case (mode)
      MIRROR_HORIZONTAL: tbl = {1'b0, tbl[1]};
      MIRROR_VERTICAL:   tbl = {1'b0, tbl[0]};
      MIRROR_SINGLE0:    tbl = 2'd0;
      MIRROR_SINGLE1:    tbl = 2'd1;
      default:           tbl = tbl;
    endcase
    return {tbl, a[OFFS_W-1:0]};
  endfunction

  // Entries 0x10, 0x14, 0x18 and 0x1C share storage with 0x00, 0x04, 0x08 and 0x0C.
  function automatic logic [PAL_AW-1:0] pal_fold(logic [VADDR_W-1:0] a);
    logic [PAL_AW-1:0] idx;
    idx = a[PAL_AW-1:0];
    if (idx[4] && (idx[1:0] == 2'b00)) begin
      idx[4] = 1'b0;
    end
    return idx;
  endfunction

endpackage

@@ design/video_memory_address_map.sv @@
`timescale 1ns / 1ps
// Video address decoder with nametable mirroring and palette folding. One access is
// taken per clock while busy is low, and its result appears on the result ports in the
// next cycle, flagged by done for exactly one cycle; the receiver cannot stall it,
// so results must be taken as they come. This rate is set by the single read/write
// port of each store and its registered read. After reset the block clears both
// stores, one nametable entry per cycle, and holds busy high until it finishes;
// register writes are taken throughout. The mirror mode register must only be
// changed while no access is in flight.
module video_memory_address_map
  import vmam_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready,
  input  logic                start,
  output logic                busy,
  input  logic                command,
  input  logic [15:0]         address,
  input  logic [DATA_W-1:0]   write_data,
  output logic                done,
  output logic [DATA_W-1:0]   read_data,
  output logic                to_cartridge,
  output logic [CADDR_W-1:0]  cartridge_address
);

  vmam_state_t        state, state_next;
  logic [NT_AW-1:0]   clr_addr, clr_addr_next;
  logic [MODE_W-1:0]  mirror_mode;
  logic               clearing;

  logic [DATA_W-1:0]  nt_mem  [NT_DEPTH];
  logic [DATA_W-1:0]  pal_mem [PAL_DEPTH];
  logic [DATA_W-1:0]  nt_q, pal_q;

  logic [VADDR_W-1:0] va;
  logic               accept, is_cart, is_pal, is_nt;
  logic [NT_AW-1:0]   nt_idx, nt_addr;
  logic [PAL_AW-1:0]  pal_idx, pal_addr;
  logic               nt_we, pal_we;
  logic [DATA_W-1:0]  wdata;

  logic               rd_nt, rd_pal;
  logic               cfg_we;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_mode <= MIRROR_HORIZONTAL;
    end else if (cfg_we && (paddr[PADDR_W-1] == REG_MIRROR_MODE)) begin
      mirror_mode <= pwdata[MODE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1] == REG_MIRROR_MODE) begin
      prdata = {{(CFG_DW-MODE_W){1'b0}}, mirror_mode};
    end
  end

  // Clearing sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    clearing      = 1'b0;
    busy          = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        clearing      = 1'b1;
        busy          = 1'b1;
        clr_addr_next = clr_addr + NT_AW'(1);
        if (clr_addr == NT_AW'(NT_DEPTH - 1)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        busy = 1'b0;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Address decode.
  assign accept  = start && !busy;
  assign va      = address[VADDR_W-1:0];
  assign is_cart = !va[VADDR_W-1];
  assign is_pal  = va[VADDR_W-1] && (va[VADDR_W-1:8] == PAL_PAGE);
  assign is_nt   = va[VADDR_W-1] && !is_pal;
  assign nt_idx  = nt_fold(va, mirror_mode);
  assign pal_idx = pal_fold(va);

  assign nt_addr  = clearing ? clr_addr : nt_idx;
  assign pal_addr = clearing ? clr_addr[PAL_AW-1:0] : pal_idx;
  assign wdata    = clearing ? '0 : write_data;
  assign nt_we    = clearing || (accept && (command == CMD_WRITE) && is_nt);
  assign pal_we   = clearing || (accept && (command == CMD_WRITE) && is_pal);

  // Each store is read and written at one address per cycle; a write and the read
  // of a later access fall on different edges, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (nt_we) begin
      nt_mem[nt_addr] <= wdata;
    end
    nt_q <= nt_mem[nt_addr];
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[pal_addr] <= wdata;
    end
    pal_q <= pal_mem[pal_addr];
  end

  // Result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= 1'b0;
      rd_nt  <= 1'b0;
      rd_pal <= 1'b0;
    end else begin
      done   <= accept;
      rd_nt  <= accept && (command == CMD_READ) && is_nt;
      rd_pal <= accept && (command == CMD_READ) && is_pal;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      to_cartridge      <= is_cart;
      cartridge_address <= is_cart ? va[CADDR_W-1:0] : '0;
    end
  end

  always_comb begin
    if (rd_nt) begin
      read_data = nt_q;
    end else if (rd_pal) begin
      read_data = pal_q;
    end else begin
      read_data = '0;
    end
  end

endmodule

@@ design/vmam_checker.sv @@
`timescale 1ns / 1ps
module vmam_assertions
  import vmam_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [DATA_W-1:0]   read_data,
  input logic                to_cartridge,
  input logic [CADDR_W-1:0]  cartridge_address
);

  // Every accepted access gives exactly one result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted access produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without an accepted access");

  // The store clearing pass always follows reset.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> busy)
    else $error("busy low right after reset");

  a_cart_no_data: assert property (@(posedge clk) disable iff (rst)
    (done && to_cartridge) |-> (read_data == '0))
    else $error("cartridge beat carries read data");

  a_internal_no_caddr: assert property (@(posedge clk) disable iff (rst)
    (done && !to_cartridge) |-> (cartridge_address == '0))
    else $error("internal beat carries a cartridge address");

endmodule

bind video_memory_address_map vmam_assertions u_vmam_assertions (.*);

@@ verif/vmam_checker.sv @@
`timescale 1ns / 1ps
module vmam_checker
  import vmam_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  input  logic               start,
  input  logic               busy,
  input  logic               command,
  input  logic [15:0]        address,
  input  logic [DATA_W-1:0]  write_data,
  input  logic               done,
  input  logic [DATA_W-1:0]  read_data,
  input  logic               to_cartridge,
  input  logic [CADDR_W-1:0] cartridge_address,
  output int                 errors,
  output int                 in_flight
);

  typedef struct packed {
    logic [DATA_W-1:0]  rd;
    logic               cart;
    logic [CADDR_W-1:0] caddr;
  } vram_result_t;

  logic [DATA_W-1:0] nt_mem [NT_DEPTH];
  logic [DATA_W-1:0] pal_mem [PAL_DEPTH];
  logic [MODE_W-1:0] mode;
  vram_result_t      pending_results [$];

  initial begin
    errors    = 0;
    in_flight = 0;
  end

  function automatic logic [NT_AW-1:0] nametable_index(logic [VADDR_W-1:0] va);
    logic [VADDR_W-1:0] rel;
    logic [1:0]         tbl;
    rel = ((va >= 14'h3000) ? va - 14'h1000 : va) - 14'h2000;
    tbl = rel[OFFS_W+1:OFFS_W];
    // Horizontal pairs tables 0/1 and 2/3; vertical pairs 0/2 and 1/3.
    case (mode)
      MIRROR_HORIZONTAL: tbl = (tbl >= 2'd2) ? 2'd1 : 2'd0;
      MIRROR_VERTICAL:   tbl = tbl & 2'd1;
      MIRROR_SINGLE0:    tbl = 2'd0;
      MIRROR_SINGLE1:    tbl = 2'd1;
      default:           ;
    endcase
    return {tbl, rel[OFFS_W-1:0]};
  endfunction

  function automatic logic [PAL_AW-1:0] palette_index(logic [VADDR_W-1:0] va);
    logic [PAL_AW-1:0] idx;
    idx = va[PAL_AW-1:0];
    if ((idx & 5'h13) == 5'h10) begin
      idx = idx & 5'h0F;
    end
    return idx;
  endfunction

  function automatic vram_result_t predict_access(logic wr, logic [15:0] addr,
                                                  logic [DATA_W-1:0] wd);
    vram_result_t       r;
    logic [VADDR_W-1:0] va;
    logic [NT_AW-1:0]   ni;
    logic [PAL_AW-1:0]  pi;
    r  = '0;
    va = addr[VADDR_W-1:0];
    if (va < 14'h2000) begin
      r.cart  = 1'b1;
      r.caddr = va[CADDR_W-1:0];
    end else if (va < 14'h3F00) begin
      ni = nametable_index(va);
      if (wr == CMD_WRITE) nt_mem[ni] = wd;
      else r.rd = nt_mem[ni];
    end else begin
      pi = palette_index(va);
      if (wr == CMD_WRITE) pal_mem[pi] = wd;
      else r.rd = pal_mem[pi];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    vram_result_t exp_r;
    if (rst) begin
      foreach (nt_mem[i]) nt_mem[i] = '0;
      foreach (pal_mem[i]) pal_mem[i] = '0;
      mode = MIRROR_HORIZONTAL;
      pending_results.delete();
    end else begin
      // A result beat always belongs to an access taken on an earlier edge.
      if (done) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, read_data %0h", $time, read_data);
        end else begin
          exp_r = pending_results.pop_front();
          if (read_data !== exp_r.rd) begin
            errors++;
            $display("%0t: read_data expected %0h, actual %0h", $time, exp_r.rd, read_data);
          end
          if (to_cartridge !== exp_r.cart) begin
            errors++;
            $display("%0t: to_cartridge expected %0b, actual %0b",
                     $time, exp_r.cart, to_cartridge);
          end
          if (cartridge_address !== exp_r.caddr) begin
            errors++;
            $display("%0t: cartridge_address expected %0h, actual %0h",
                     $time, exp_r.caddr, cartridge_address);
          end
        end
      end
      if (psel && penable && pwrite && pready &&
          paddr[PADDR_W-1:2] == REG_MIRROR_MODE) begin
        mode = pwdata[MODE_W-1:0];
      end
      if (start && !busy) begin
        pending_results.push_back(predict_access(command, address, write_data));
      end
    end
    in_flight = pending_results.size();
  end

endmodule

@@ verif/tb_video_memory_address_map.sv @@
`timescale 1ns / 1ps
module tb_video_memory_address_map;
  import vmam_pkg::*;

  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 170;
  // The clearing pass after reset holds busy while it clears all 4096 nametable entries.
  localparam int STALL_LIMIT = 12000;

  localparam logic [MODE_W-1:0] MIRROR_UNDEF_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MIRROR_UNDEF_MID   = 3'd6;
  localparam logic [MODE_W-1:0] MIRROR_UNDEF_LAST  = 3'd7;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               psel       = 1'b0;
  logic               penable    = 1'b0;
  logic               pwrite     = 1'b0;
  logic [PADDR_W-1:0] paddr      = '0;
  logic [CFG_DW-1:0]  pwdata     = '0;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;
  logic               start      = 1'b0;
  logic               busy;
  logic               command    = CMD_READ;
  logic [15:0]        address    = '0;
  logic [DATA_W-1:0]  write_data = '0;
  logic               done;
  logic [DATA_W-1:0]  read_data;
  logic               to_cartridge;
  logic [CADDR_W-1:0] cartridge_address;

  int errors;
  int in_flight;
  int stall_cycles = 0;
  int items_sent   = 0;
  int mode_writes  = 0;
  bit allow_idle   = 1'b1;

  logic [VADDR_W-1:0] recent_addr [8];
  int                 recent_wr = 0;

  video_memory_address_map dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .command(command), .address(address), .write_data(write_data),
    .done(done), .read_data(read_data), .to_cartridge(to_cartridge),
    .cartridge_address(cartridge_address)
  );

  vmam_checker vram_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .start(start), .busy(busy),
    .command(command), .address(address), .write_data(write_data),
    .done(done), .read_data(read_data), .to_cartridge(to_cartridge),
    .cartridge_address(cartridge_address),
    .errors(errors), .in_flight(in_flight)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_mirror_mode(input logic [MODE_W-1:0] m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MIRROR_MODE, 2'b00};
    pwdata  <= CFG_DW'(m);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mode_writes++;
  endtask

  task automatic send_access(input logic cmd, input logic [15:0] addr,
                             input logic [DATA_W-1:0] wd);
    start      <= 1'b1;
    command    <= cmd;
    address    <= addr;
    write_data <= wd;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic idle_burst();
    if (allow_idle && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Stop issuing and let every outstanding beat come back before touching the register.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Just under half of the addresses revisit a recent write, possibly through a mirror or table alias,
  // so that reads actually observe stored data.
  function automatic logic [15:0] pick_address();
    logic [VADDR_W-1:0] va;
    logic [VADDR_W-1:0] flip;
    int                 sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      case ($urandom_range(0, 7))
        0:       flip = 14'h0000;
        1:       flip = 14'h0400;
        2:       flip = 14'h0800;
        3:       flip = 14'h0C00;
        4:       flip = 14'h1000;
        5:       flip = 14'h0010;
        6:       flip = 14'h0020;
        default: flip = 14'h00E0;
      endcase
      va = recent_addr[$urandom_range(0, 7)] ^ flip;
    end else if (sel < 60) begin
      va = VADDR_W'($urandom_range(0, 14'h1FFF));
    end else if (sel < 85) begin
      va = VADDR_W'(14'h2000 + $urandom_range(0, 14'h1EFF));
    end else begin
      va = VADDR_W'(14'h3F00 | $urandom_range(0, 255));
    end
    return {2'($urandom_range(0, 3)), va};
  endfunction

  task automatic random_access();
    logic        cmd;
    logic [15:0] addr;
    cmd  = ($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ;
    addr = pick_address();
    if (cmd == CMD_WRITE) begin
      recent_addr[recent_wr] = addr[VADDR_W-1:0];
      recent_wr = (recent_wr + 1) % 8;
    end
    send_access(cmd, addr, DATA_W'($urandom_range(0, 255)));
  endtask

  function automatic logic [MODE_W-1:0] phase_mode(int p);
    case (p)
      0:       return MIRROR_HORIZONTAL;
      1:       return MIRROR_VERTICAL;
      2:       return MIRROR_SINGLE0;
      3:       return MIRROR_SINGLE1;
      4:       return MIRROR_FOUR;
      5:       return MIRROR_UNDEF_FIRST;
      6:       return MIRROR_UNDEF_MID;
      7:       return MIRROR_UNDEF_LAST;
      8:       return MODE_W'($urandom_range(0, 7));
      default: return MIRROR_HORIZONTAL;
    endcase
  endfunction

  initial begin
    foreach (recent_addr[i]) recent_addr[i] = VADDR_W'(32'h2000 + 32'h0400 * i);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_mirror_mode(MIRROR_FOUR);

    // Four distinct tables, then the 0x3000 mirror and the top of the nametable region.
    send_access(CMD_WRITE, 16'h2000, 8'hFF); idle_burst();
    send_access(CMD_WRITE, 16'h2400, 8'h01); idle_burst();
    send_access(CMD_WRITE, 16'h2800, 8'h80); idle_burst();
    send_access(CMD_WRITE, 16'h2FFF, 8'h7F); idle_burst();
    send_access(CMD_READ,  16'h3000, 8'h00); idle_burst();
    send_access(CMD_READ,  16'h3EFF, 8'hFF); idle_burst();
    send_access(CMD_READ,  16'hEBFF, 8'h00); idle_burst();
    send_access(CMD_READ,  16'h2FFF, 8'h00); idle_burst();
    // Cartridge accesses, including ones with the ignored upper bits set.
    send_access(CMD_READ,  16'h0000, 8'h00); idle_burst();
    send_access(CMD_WRITE, 16'h1FFF, 8'hAA); idle_burst();
    send_access(CMD_READ,  16'hDFFF, 8'h55); idle_burst();
    send_access(CMD_WRITE, 16'h4000, 8'hFF); idle_burst();
    // Palette aliases, also reached through the 0x3F20 to 0x3FFF mirrors.
    send_access(CMD_WRITE, 16'h3F10, 8'h5A); idle_burst();
    send_access(CMD_READ,  16'h3F00, 8'h00); idle_burst();
    send_access(CMD_WRITE, 16'h3F0C, 8'h3C); idle_burst();
    send_access(CMD_READ,  16'h3F1C, 8'h00); idle_burst();
    send_access(CMD_READ,  16'h3F3C, 8'h00); idle_burst();
    send_access(CMD_WRITE, 16'hFFFF, 8'hC3); idle_burst();
    send_access(CMD_READ,  16'h3F1F, 8'h00); idle_burst();
    send_access(CMD_WRITE, 16'h3F24, 8'h11); idle_burst();
    send_access(CMD_READ,  16'h3F14, 8'h00); idle_burst();
    send_access(CMD_WRITE, 16'h3F01, 8'h00); idle_burst();
    send_access(CMD_READ,  16'h3F21, 8'hFF); idle_burst();

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_mirror_mode(phase_mode(p));
      allow_idle = (p != PHASES - 1);
      repeat (PHASE_ITEMS) begin
        random_access();
        idle_burst();
      end
    end
    drain();

    $display("Run covered %0d accesses over cartridge, nametable and palette regions,",
             items_sent);
    $display("with %0d mirror-mode writes spanning every mode code.", mode_writes);
    if (errors == 0 && in_flight == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

@@ video_memory_address_map.f @@
design/vmam_pkg.sv
design/video_memory_address_map.sv
design/vmam_checker.sv
verif/vmam_checker.sv
verif/tb_video_memory_address_map.sv
